// File: rtl/core/strs_pkg.sv
// shared constants, types and control store of the slot timed release sequencer
package strs_pkg;

   localparam int SLOT_BITS     = 24;
   localparam int SPR_BITS      = 8;
   localparam int DROP_BITS     = 23;
   localparam int LEFT_BITS     = SLOT_BITS + SPR_BITS;
   localparam int DIVIDEND_BITS = ((DROP_BITS > SLOT_BITS) ? DROP_BITS : SLOT_BITS) + 1;
   localparam int CNT_BITS      = $clog2(DIVIDEND_BITS);
   localparam int CSR_ADDR_BITS = 3;
   localparam int CSR_DATA_BITS = 32;

   localparam logic [DROP_BITS-1:0] DROP_DELAY_RESET = DROP_BITS'(316121);
   localparam logic [SPR_BITS-1:0]  SLOTS_RESET      = SPR_BITS'(18);
   localparam logic [SLOT_BITS-1:0] SLOT_MAX         = {SLOT_BITS{1'b1}};

   localparam logic REG_DROP_DELAY      = 1'b0;
   localparam logic REG_SLOTS_PER_ROUND = 1'b1;

   localparam logic [2:0] PH_WAIT_PRESS   = 3'd0;
   localparam logic [2:0] PH_WAIT_RELEASE = 3'd1;
   localparam logic [2:0] PH_WAIT_SENSOR  = 3'd2;
   localparam logic [2:0] PH_MEASURE      = 3'd3;
   localparam logic [2:0] PH_COMPUTE      = 3'd4;
   localparam logic [2:0] PH_COUNT        = 3'd5;
   localparam logic [2:0] PH_HALT         = 3'd6;

   typedef logic [2:0] upc_type;

   typedef enum logic [2:0] {
      OP_NONE,
      OP_LATCH,
      OP_STEP,
      OP_MUL,
      OP_DIV,
      OP_LOAD,
      OP_EMIT
   } op_type;

   typedef enum logic [2:0] {
      COND_ALWAYS,
      COND_REQ,
      COND_PH_COMPUTE,
      COND_CNT_NZ,
      COND_OUT_FREE
   } cond_type;

   typedef struct packed {
      op_type   op;
      cond_type cond;
      upc_type  on_true;
      upc_type  on_false;
   } uword_type;

   localparam upc_type UPC_WAIT     = 3'd0;
   localparam upc_type UPC_DISPATCH = 3'd1;
   localparam upc_type UPC_STEP     = 3'd2;
   localparam upc_type UPC_MUL      = 3'd3;
   localparam upc_type UPC_DIV      = 3'd4;
   localparam upc_type UPC_LOAD     = 3'd5;
   localparam upc_type UPC_EMIT     = 3'd6;

   function automatic uword_type ucode_rom(input upc_type addr);
      uword_type w;
      case (addr)
         UPC_WAIT:     w = '{OP_LATCH, COND_REQ,        UPC_DISPATCH, UPC_WAIT};
         UPC_DISPATCH: w = '{OP_NONE,  COND_PH_COMPUTE, UPC_MUL,      UPC_STEP};
         UPC_STEP:     w = '{OP_STEP,  COND_ALWAYS,     UPC_EMIT,     UPC_EMIT};
         UPC_MUL:      w = '{OP_MUL,   COND_ALWAYS,     UPC_DIV,      UPC_DIV};
         UPC_DIV:      w = '{OP_DIV,   COND_CNT_NZ,     UPC_DIV,      UPC_LOAD};
         UPC_LOAD:     w = '{OP_LOAD,  COND_ALWAYS,     UPC_EMIT,     UPC_EMIT};
         UPC_EMIT:     w = '{OP_EMIT,  COND_OUT_FREE,   UPC_WAIT,     UPC_EMIT};
         default:      w = '{OP_NONE,  COND_ALWAYS,     UPC_WAIT,     UPC_WAIT};
      endcase
      return w;
   endfunction

endpackage

// File: rtl/core/strs_chan_if.sv
// request and response channel interfaces of the slot timed release sequencer
interface strs_req_if;
   logic valid;
   logic ready;
   logic trigger_level;
   logic sensor_level;

   modport source (output valid, output trigger_level, output sensor_level, input ready);
   modport sink   (input valid, input trigger_level, input sensor_level, output ready);
endinterface

interface strs_rsp_if;
   logic       valid;
   logic       ready;
   logic       magnet_hold;
   logic [2:0] progress;

   modport source (output valid, output magnet_hold, output progress, input ready);
   modport sink   (input valid, input magnet_hold, input progress, output ready);
endinterface

// File: rtl/core/slot_timed_release_sequencer_core.sv
// top level of the slot timed release sequencer: control store, datapath and register port
//
// One request is one timer tick carrying the trigger and slot sensor levels; every request
// gives exactly one response with the magnet drive and the step reached. A small control
// store steps a plain datapath. A tick in any step but the countdown computation passes
// through the dispatch, step and emit words of the control store, and its response is
// registered by the emit word, which waits until the output register is free. The tick that
// computes the countdown passes through dispatch, then the round-time multiply, then a
// restoring divider that retires one remainder bit per clock, then the load and emit. A
// new request is taken as soon as the control store is back at
// its wait step, even while the previous response still sits unread in the output
// register. Registers: drop_delay at byte address 0, slots_per_round at byte address 4;
// written values count only when the countdown is computed.
module slot_timed_release_sequencer_core (
   input  logic                              clock,
   input  logic                              reset,
   strs_req_if.sink                          req_chan,
   strs_rsp_if.source                        rsp_chan,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [strs_pkg::CSR_ADDR_BITS-1:0] csr_paddr,
   input  logic [strs_pkg::CSR_DATA_BITS-1:0] csr_pwdata,
   output logic [strs_pkg::CSR_DATA_BITS-1:0] csr_prdata,
   output logic                              csr_pready
);
   import strs_pkg::*;

   localparam logic [CNT_BITS-1:0] CNT_LAST = CNT_BITS'(DIVIDEND_BITS - 1);

   upc_type                  upc_ff, upc_in;
   logic [2:0]               phase_ff, phase_in;
   logic [SLOT_BITS-1:0]     slot_ff, slot_in;
   logic [LEFT_BITS-1:0]     left_ff, left_in;
   logic [LEFT_BITS-1:0]     round_ff, round_in;
   logic [LEFT_BITS-1:0]     rem_ff, rem_in;
   logic [DIVIDEND_BITS-1:0] dividend_ff, dividend_in;
   logic [CNT_BITS-1:0]      cnt_ff, cnt_in;
   logic                     trig_ff, trig_in;
   logic                     sens_ff, sens_in;
   logic [DROP_BITS-1:0]     drop_ff, drop_in;
   logic [SPR_BITS-1:0]      spr_ff, spr_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic                     rsp_hold_ff, rsp_hold_in;
   logic [2:0]               rsp_progress_ff, rsp_progress_in;

   uword_type                uword;
   logic                     cond_true;
   logic                     out_free;
   logic                     csr_write;
   logic [LEFT_BITS:0]       rem_shift;
   logic [LEFT_BITS:0]       rem_trial;
   logic [LEFT_BITS-1:0]     left_dec;
   logic [LEFT_BITS-1:0]     countdown;

   assign uword     = ucode_rom(upc_ff);
   assign out_free  = !rsp_valid_ff || rsp_chan.ready;
   assign csr_write = csr_psel && csr_penable && csr_pwrite;

   assign req_chan.ready       = (uword.op == OP_LATCH);
   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.magnet_hold = rsp_hold_ff;
   assign rsp_chan.progress    = rsp_progress_ff;

   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[2] == REG_SLOTS_PER_ROUND) ?
                       CSR_DATA_BITS'(spr_ff) : CSR_DATA_BITS'(drop_ff);

   assign rem_shift = {rem_ff, dividend_ff[DIVIDEND_BITS-1]};
   assign rem_trial = rem_shift - {1'b0, round_ff};
   assign left_dec  = (left_ff != '0) ? (left_ff - LEFT_BITS'(1)) : left_ff;
   assign countdown = ((round_ff == '0) || (rem_ff == '0)) ? '0 : (round_ff - rem_ff);

   always_comb begin
      case (uword.cond)
         COND_ALWAYS:     cond_true = 1'b1;
         COND_REQ:        cond_true = req_chan.valid;
         COND_PH_COMPUTE: cond_true = (phase_ff == PH_COMPUTE);
         COND_CNT_NZ:     cond_true = (cnt_ff != '0);
         COND_OUT_FREE:   cond_true = out_free;
         default:         cond_true = 1'b1;
      endcase
   end

   always_comb begin
      upc_in          = cond_true ? uword.on_true : uword.on_false;
      phase_in        = phase_ff;
      slot_in         = slot_ff;
      left_in         = left_ff;
      round_in        = round_ff;
      rem_in          = rem_ff;
      dividend_in     = dividend_ff;
      cnt_in          = cnt_ff;
      trig_in         = trig_ff;
      sens_in         = sens_ff;
      drop_in         = drop_ff;
      spr_in          = spr_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp_chan.ready;
      rsp_hold_in     = rsp_hold_ff;
      rsp_progress_in = rsp_progress_ff;

      if (csr_write) begin
         if (csr_paddr[2] == REG_SLOTS_PER_ROUND) begin
            spr_in = csr_pwdata[SPR_BITS-1:0];
         end else begin
            drop_in = csr_pwdata[DROP_BITS-1:0];
         end
      end

      case (uword.op)
         OP_LATCH: begin
            if (req_chan.valid) begin
               trig_in = req_chan.trigger_level;
               sens_in = req_chan.sensor_level;
            end
         end
         OP_STEP: begin
            case (phase_ff)
               PH_WAIT_PRESS: begin
                  if (!trig_ff) phase_in = PH_WAIT_RELEASE;
               end
               PH_WAIT_RELEASE: begin
                  if (trig_ff) phase_in = PH_WAIT_SENSOR;
               end
               PH_WAIT_SENSOR: begin
                  if (sens_ff) begin
                     slot_in  = SLOT_BITS'(1);
                     phase_in = PH_MEASURE;
                  end
               end
               PH_MEASURE: begin
                  if (sens_ff) begin
                     if (slot_ff != SLOT_MAX) slot_in = slot_ff + SLOT_BITS'(1);
                  end else begin
                     phase_in = PH_COMPUTE;
                  end
               end
               PH_COUNT: begin
                  left_in = left_dec;
                  if (left_dec == '0) phase_in = PH_HALT;
               end
               default: begin
               end
            endcase
         end
         OP_MUL: begin
            round_in    = LEFT_BITS'(slot_ff) * LEFT_BITS'(spr_ff);
            dividend_in = DIVIDEND_BITS'(drop_ff) + DIVIDEND_BITS'(slot_ff);
            rem_in      = '0;
            cnt_in      = CNT_LAST;
         end
         OP_DIV: begin
            rem_in      = rem_trial[LEFT_BITS] ? rem_shift[LEFT_BITS-1:0]
                                               : rem_trial[LEFT_BITS-1:0];
            dividend_in = {dividend_ff[DIVIDEND_BITS-2:0], 1'b0};
            cnt_in      = cnt_ff - CNT_BITS'(1);
         end
         OP_LOAD: begin
            left_in  = countdown;
            phase_in = (countdown == '0) ? PH_HALT : PH_COUNT;
         end
         OP_EMIT: begin
            if (out_free) begin
               rsp_valid_in    = 1'b1;
               rsp_hold_in     = (phase_ff < PH_HALT);
               rsp_progress_in = phase_ff;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         upc_ff       <= UPC_WAIT;
         phase_ff     <= PH_WAIT_PRESS;
         slot_ff      <= '0;
         left_ff      <= '0;
         drop_ff      <= DROP_DELAY_RESET;
         spr_ff       <= SLOTS_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         upc_ff       <= upc_in;
         phase_ff     <= phase_in;
         slot_ff      <= slot_in;
         left_ff      <= left_in;
         drop_ff      <= drop_in;
         spr_ff       <= spr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      round_ff        <= round_in;
      rem_ff          <= rem_in;
      dividend_ff     <= dividend_in;
      cnt_ff          <= cnt_in;
      trig_ff         <= trig_in;
      sens_ff         <= sens_in;
      rsp_hold_ff     <= rsp_hold_in;
      rsp_progress_ff <= rsp_progress_in;
   end

   // steps only move forward until reset
   assert property (@(posedge clock) disable iff (reset)
      ##1 (phase_ff >= $past(phase_ff)))
      else $error("step went backwards");

   // counting down never holds a spent countdown
   assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_COUNT) |-> (left_ff != '0))
      else $error("countdown step with zero ticks left");

   // a slot being measured always has at least one tick
   assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_MEASURE) |-> (slot_ff != '0))
      else $error("slot measurement with zero count");

   // magnet drive in a response matches its step
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_hold_ff == (rsp_progress_ff < PH_HALT)))
      else $error("magnet drive disagrees with step");

   // a request is only taken at the wait step of the control store
   assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_chan.ready) |=> (upc_ff == UPC_DISPATCH))
      else $error("request taken outside the wait step");

endmodule

// File: verif/tb_top.sv
// self-checking testbench of the slot timed release sequencer core
`timescale 1ns / 1ps

module tb_top;
   import strs_pkg::*;

   localparam int  IDLE_PCT    = 7;
   localparam int  DRAIN_PAUSE = 40;
   localparam int  STALL_LIMIT = 2000;
   localparam int  HOLD_CYCLES = 300;
   localparam int  DROP_MAX    = (1 << DROP_BITS) - 1;

   typedef enum int {PLAN_COUNTDOWN, PLAN_NO_SLOTS, PLAN_EXACT_HIT} release_plan_type;

   typedef struct packed {
      logic       magnet;
      logic [2:0] progress;
   } drive_type;

   logic clock;
   logic reset;
   logic csr_psel;
   logic csr_penable;
   logic csr_pwrite;
   logic [CSR_ADDR_BITS-1:0] csr_paddr;
   logic [CSR_DATA_BITS-1:0] csr_pwdata;
   logic [CSR_DATA_BITS-1:0] csr_prdata;
   logic csr_pready;

   strs_req_if req_chan ();
   strs_rsp_if rsp_chan ();

   slot_timed_release_sequencer_core u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_chan),
      .rsp_chan    (rsp_chan),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // shadow of the sequencer state and registers
   logic [2:0]           phase_m;
   logic [SLOT_BITS-1:0] slot_len;
   logic [LEFT_BITS-1:0] count_left;
   logic [DROP_BITS-1:0] cfg_drop;
   logic [SPR_BITS-1:0]  cfg_spr;

   drive_type pending_drive[$];
   int     mismatches;
   bit     no_idle;
   int     hold_request;
   int     hold_left;
   int     quiet_cycles;
   release_plan_type plan;

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   function automatic logic [LEFT_BITS-1:0] release_countdown(
      input logic [SLOT_BITS-1:0] slot,
      input logic [DROP_BITS-1:0] drop,
      input logic [SPR_BITS-1:0]  spr
   );
      longint unsigned period;
      longint unsigned offset;
      period = longint'(slot) * longint'(spr);
      if (period == 0) begin
         return '0;
      end
      offset = (longint'(drop) + longint'(slot)) % period;
      return LEFT_BITS'((period - offset) % period);
   endfunction

   task automatic step_sequencer(input logic trig, input logic sens, output drive_type outcome);
      case (phase_m)
         PH_WAIT_PRESS: begin
            if (!trig) phase_m = PH_WAIT_RELEASE;
         end
         PH_WAIT_RELEASE: begin
            if (trig) phase_m = PH_WAIT_SENSOR;
         end
         PH_WAIT_SENSOR: begin
            if (sens) begin
               slot_len = SLOT_BITS'(1);
               phase_m  = PH_MEASURE;
            end
         end
         PH_MEASURE: begin
            if (sens) begin
               if (slot_len != SLOT_MAX) slot_len = slot_len + 1'b1;
            end else begin
               phase_m = PH_COMPUTE;
            end
         end
         PH_COMPUTE: begin
            count_left = release_countdown(slot_len, cfg_drop, cfg_spr);
            phase_m    = (count_left == 0) ? PH_HALT : PH_COUNT;
         end
         PH_COUNT: begin
            if (count_left != 0) count_left = count_left - 1'b1;
            if (count_left == 0) phase_m = PH_HALT;
         end
         default: begin
         end
      endcase
      outcome.magnet   = (phase_m >= PH_HALT) ? 1'b0 : 1'b1;
      outcome.progress = phase_m;
   endtask

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
      mismatches++;
   endtask

   task automatic send_tick(input logic trig, input logic sens);
      drive_type outcome;
      while (!no_idle && $urandom_range(0, 99) < IDLE_PCT) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid         <= 1'b1;
      req_chan.trigger_level <= trig;
      req_chan.sensor_level  <= sens;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      step_sequencer(trig, sens, outcome);
      pending_drive.push_back(outcome);
   endtask

   // lower valid and let every response come back, then pause before going on
   task automatic drain_requests();
      req_chan.valid <= 1'b0;
      while (pending_drive.size() != 0) @(posedge clock);
      repeat (DRAIN_PAUSE) @(posedge clock);
   endtask

   task automatic csr_write(input logic idx, input logic [CSR_DATA_BITS-1:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= CSR_ADDR_BITS'(idx) << 2;
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      if (idx == REG_DROP_DELAY) cfg_drop = value[DROP_BITS-1:0];
      else cfg_spr = value[SPR_BITS-1:0];
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic test_register_extremes();
      csr_write(REG_DROP_DELAY, '0);
      csr_write(REG_SLOTS_PER_ROUND, 255);
      csr_write(REG_DROP_DELAY, DROP_MAX);
      csr_write(REG_SLOTS_PER_ROUND, 0);
      csr_write(REG_SLOTS_PER_ROUND, 1);
      csr_write(REG_DROP_DELAY, DROP_DELAY_RESET);
   endtask

   task automatic test_arming_walk();
      send_tick(1'b1, 1'b0);
      send_tick(1'b1, 1'b1);
      send_tick(1'b0, 1'b1);
      send_tick(1'b0, 1'b0);
      send_tick(1'b0, 1'b1);
      send_tick(1'b1, 1'b0);
      send_tick(1'b0, 1'b0);
      send_tick(1'b1, 1'b0);
   endtask

   // trigger toggles at random while the sensor stays low
   task automatic test_sensor_wait_noise(input int ticks);
      repeat (ticks) send_tick(1'($urandom_range(0, 1)), 1'b0);
   endtask

   task automatic test_slot_measure(input int slot_target);
      no_idle = 1'b1;
      repeat (slot_target) send_tick(1'($urandom_range(0, 1)), 1'b1);
      no_idle = 1'b0;
      send_tick(1'($urandom_range(0, 1)), 1'b0);
   endtask

   task automatic test_release_setup(output int countdown_target);
      longint unsigned period;
      longint unsigned base;
      longint unsigned k_max;
      int lo;
      int spr;
      int c;
      drain_requests();
      case (plan)
         PLAN_NO_SLOTS: begin
            spr = 0;
            c   = 0;
            csr_write(REG_DROP_DELAY, $urandom_range(0, DROP_MAX));
         end
         PLAN_EXACT_HIT: begin
            spr    = $urandom_range(1, 255);
            period = longint'(slot_len) * spr;
            c      = 0;
            base   = (period - (longint'(slot_len) % period)) % period;
         end
         default: begin
            c  = $urandom_range(400, 700);
            lo = c / int'(slot_len) + 1;
            if (lo > 255) lo = 255;
            spr    = $urandom_range(lo, 255);
            period = longint'(slot_len) * spr;
            if (c >= period) c = int'(period) - 1;
            base = ((period - c) + period - (longint'(slot_len) % period)) % period;
         end
      endcase
      if (plan != PLAN_NO_SLOTS) begin
         k_max = (DROP_MAX - base) / period;
         if ($urandom_range(0, 3) == 0) begin
            csr_write(REG_DROP_DELAY, CSR_DATA_BITS'(base + k_max * period));
         end else begin
            csr_write(REG_DROP_DELAY,
                      CSR_DATA_BITS'(base + $urandom_range(0, int'(k_max)) * period));
         end
      end
      csr_write(REG_SLOTS_PER_ROUND, spr);
      countdown_target = c;
   endtask

   task automatic test_countdown();
      int sent;
      sent = 0;
      hold_request = HOLD_CYCLES;
      while (phase_m != PH_HALT) begin
         no_idle = (sent > 150 && sent < 300);
         send_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
         sent++;
      end
      no_idle = 1'b0;
      drain_requests();
   endtask

   task automatic test_halted();
      repeat (6) send_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
   endtask

   always @(posedge clock) begin
      if (hold_left > 0) begin
         rsp_chan.ready <= 1'b0;
         hold_left = hold_left - 1;
      end else if (hold_request != 0) begin
         rsp_chan.ready <= 1'b0;
         hold_left = hold_request - 1;
         hold_request = 0;
      end else begin
         rsp_chan.ready <= no_idle || ($urandom_range(0, 99) >= IDLE_PCT);
      end
   end

   always @(posedge clock) begin
      drive_type want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (pending_drive.size() == 0) begin
            report_mismatch("unexpected response, progress", rsp_chan.progress, -1);
         end else begin
            want = pending_drive.pop_front();
            if (rsp_chan.magnet_hold !== want.magnet)
               report_mismatch("magnet_hold", rsp_chan.magnet_hold, want.magnet);
            if (rsp_chan.progress !== want.progress)
               report_mismatch("progress", rsp_chan.progress, want.progress);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles = quiet_cycles + 1;
      end
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   initial begin
      int slot_target;
      int countdown_target;
      mismatches   = 0;
      no_idle      = 1'b0;
      hold_request = 0;
      hold_left    = 0;
      quiet_cycles = 0;
      phase_m      = PH_WAIT_PRESS;
      slot_len     = '0;
      count_left   = '0;
      cfg_drop     = DROP_DELAY_RESET;
      cfg_spr      = SLOTS_RESET;
      reset                  <= 1'b1;
      req_chan.valid         <= 1'b0;
      req_chan.trigger_level <= 1'b1;
      req_chan.sensor_level  <= 1'b0;
      csr_psel               <= 1'b0;
      csr_penable            <= 1'b0;
      csr_pwrite             <= 1'b0;
      csr_paddr              <= '0;
      csr_pwdata             <= '0;
      case ($urandom_range(0, 9))
         0:       plan = PLAN_NO_SLOTS;
         1:       plan = PLAN_EXACT_HIT;
         default: plan = PLAN_COUNTDOWN;
      endcase
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_register_extremes();
      test_arming_walk();
      test_sensor_wait_noise(plan == PLAN_COUNTDOWN ? $urandom_range(150, 250)
                                                    : $urandom_range(250, 350));
      slot_target = (plan == PLAN_COUNTDOWN) ? $urandom_range(3, 250) : $urandom_range(400, 700);
      test_slot_measure(slot_target);
      test_release_setup(countdown_target);
      test_countdown();
      test_halted();

      drain_requests();
      if (mismatches == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

// File: files.f
rtl/core/strs_pkg.sv
rtl/core/strs_chan_if.sv
rtl/core/slot_timed_release_sequencer_core.sv
verif/tb_top.sv
